@@ rtl/segment_tree_range_query_core_assert.svh @@
// Assertion macros shared by the segment tree RTL.
`ifndef SEGMENT_TREE_RANGE_QUERY_CORE_ASSERT_SVH
`define SEGMENT_TREE_RANGE_QUERY_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define STRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define STRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/strq_pkg.sv @@
// Shared constants, codes and types of the segment tree range query core.
package strq_pkg;

    localparam int MAX_LEAVES = 1024;
    localparam int LEAF_W     = $clog2(MAX_LEAVES);
    localparam int NODE_W     = LEAF_W + 1;
    localparam int TREE_SLOTS = 1 << NODE_W;
    localparam int CNT_W      = LEAF_W + 1;
    localparam int STK_DEPTH  = LEAF_W;
    localparam int LVL_W      = $clog2(LEAF_W + 1);
    localparam int VAL_W      = 60;

    localparam logic [VAL_W-1:0] SAT_LIMIT = 60'd1000000000000000000;

    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVES = 2'd1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic {
        ALU_MAX,
        ALU_SAT_ADD
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VISIT,
        ST_QREAD,
        ST_LEAF_WR,
        ST_RETURN,
        ST_ADD_RDL,
        ST_ADD_RDR,
        ST_ADD_WR,
        ST_PUSH
    } t_state;

endpackage

@@ rtl/strq_alu.sv @@
// Shared combine unit: maximum or sum saturating at the limit.
module strq_alu (
    input  strq_pkg::t_alu_op               i_op,
    input  logic [strq_pkg::VAL_W-1:0]      i_x,
    input  logic [strq_pkg::VAL_W-1:0]      i_y,
    output logic [strq_pkg::VAL_W-1:0]      o_r
);
    import strq_pkg::*;

    logic [VAL_W-1:0] x_c;
    logic [VAL_W-1:0] y_c;
    logic [VAL_W:0]   sum;

    // operands are clipped first; max of clipped equals clipped max
    assign x_c = (i_x > SAT_LIMIT) ? SAT_LIMIT : i_x;
    assign y_c = (i_y > SAT_LIMIT) ? SAT_LIMIT : i_y;
    assign sum = {1'b0, x_c} + {1'b0, y_c};

    always_comb begin
        unique case (i_op)
            ALU_SAT_ADD: begin
                o_r = (sum > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : sum[VAL_W-1:0];
            end
            ALU_MAX: begin
                o_r = (x_c > y_c) ? x_c : y_c;
            end
        endcase
    end

endmodule

@@ rtl/segment_tree_range_query_core.sv @@
// Segment tree over up to 1024 leaves: range add and range max / saturated-sum query.
// The block walks the tree depth first under a small sequencer, one node step at a time,
// with a 2048 x 60 node memory (write port, registered read port), one shared combine unit.
// One item is in flight at a time; o_s_tready is high only when the walker is idle.
// A query descends only into nodes that straddle the range and reads each node that lies
// wholly inside it. An add visits every node over the leaves it touches, writes each such
// leaf and recomputes every parent on the way back up.
// After reset every slot of the node memory is cleared before the first request is taken;
// configuration writes are taken at any time.
`include "segment_tree_range_query_core_assert.svh"

module segment_tree_range_query_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [strq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [strq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [strq_pkg::S_TDATA_W-1:0]      i_s_tdata,  // range_first, range_last, amount
    input  logic                                i_s_tuser,  // cmd
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [strq_pkg::M_TDATA_W-1:0]      o_m_tdata   // combined, zero pad
);
    import strq_pkg::*;

    t_state r_state, n_state;

    logic                  r_mode;
    logic [CNT_W-1:0]      r_leaves;
    logic [NODE_W-1:0]     r_clr;

    logic                  r_cmd;
    logic [LEAF_W-1:0]     r_lo, r_hi;
    logic [VAL_W-1:0]      r_amt;

    logic [NODE_W-1:0]     r_k, n_k;
    logic [LEAF_W-1:0]     r_a, n_a, r_b, n_b;
    logic [LVL_W-1:0]      r_d, n_d;
    logic [VAL_W-1:0]      r_ret, n_ret, r_tmp, n_tmp;

    logic [LEAF_W-1:0]     r_stk_a [STK_DEPTH];
    logic [LEAF_W-1:0]     r_stk_b [STK_DEPTH];
    logic [VAL_W-1:0]      r_acc   [STK_DEPTH];

    logic [VAL_W-1:0]      r_mem   [TREE_SLOTS];
    logic [VAL_W-1:0]      r_rdata;

    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_data;

    logic                  s_acc;
    logic                  is_query;
    logic                  disjoint, covered, is_leaf;
    logic [LEAF_W:0]       sum_ab, sum_p;
    logic [LEAF_W-1:0]     mid, pmid, pa, pb, root_b;
    logic [CNT_W-1:0]      leaves_m1;
    logic [LVL_W-1:0]      up;

    logic                  push_en, acc_we, out_load;
    logic                  mem_we;
    logic [NODE_W-1:0]     mem_waddr, mem_raddr;
    logic [VAL_W-1:0]      mem_wdata;

    t_alu_op               alu_op, mode_op;
    logic [VAL_W-1:0]      alu_x, alu_y, alu_r;

    strq_alu u_alu (
        .i_op (alu_op),
        .i_x  (alu_x),
        .i_y  (alu_y),
        .o_r  (alu_r)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(M_TDATA_W-VAL_W){1'b0}}, r_out_data};

    assign is_query = (r_cmd == CMD_QUERY);
    assign mode_op  = r_mode ? ALU_SAT_ADD : ALU_MAX;

    assign disjoint = (r_a > r_hi) || (r_b < r_lo);
    assign covered  = (r_a >= r_lo) && (r_b <= r_hi);
    assign is_leaf  = (r_a == r_b);

    assign sum_ab = {1'b0, r_a} + {1'b0, r_b};
    assign mid    = sum_ab[LEAF_W:1];

    // parent frame sits one level up
    assign up   = (r_d == '0) ? '0 : r_d - LVL_W'(1);
    assign pa   = r_stk_a[up];
    assign pb   = r_stk_b[up];
    assign sum_p = {1'b0, pa} + {1'b0, pb};
    assign pmid  = sum_p[LEAF_W:1];

    assign leaves_m1 = r_leaves - CNT_W'(1);
    always_comb begin
        priority if (r_leaves == '0) begin
            root_b = '0;
        end else if (r_leaves > CNT_W'(MAX_LEAVES)) begin
            root_b = LEAF_W'(MAX_LEAVES - 1);
        end else begin
            root_b = leaves_m1[LEAF_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) n_state = ST_VISIT;
            end
            ST_VISIT: begin
                priority if (disjoint) begin
                    n_state = ST_RETURN;
                end else if (is_query && covered) begin
                    n_state = ST_QREAD;
                end else if (!is_query && is_leaf) begin
                    n_state = ST_LEAF_WR;
                end else begin
                    n_state = ST_VISIT;
                end
            end
            ST_QREAD:   n_state = ST_RETURN;
            ST_LEAF_WR: n_state = ST_RETURN;
            ST_RETURN: begin
                priority if (r_d == '0) begin
                    n_state = is_query ? ST_PUSH : ST_IDLE;
                end else if (!r_k[0]) begin
                    n_state = ST_VISIT;
                end else begin
                    n_state = is_query ? ST_RETURN : ST_ADD_RDL;
                end
            end
            ST_ADD_RDL: n_state = ST_ADD_RDR;
            ST_ADD_RDR: n_state = ST_ADD_WR;
            ST_ADD_WR:  n_state = ST_RETURN;
            ST_PUSH: begin
                if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // combine unit operands
    always_comb begin
        alu_op = mode_op;
        alu_x  = r_tmp;
        alu_y  = r_rdata;
        unique case (r_state)
            ST_LEAF_WR: begin
                alu_op = ALU_SAT_ADD;
                alu_x  = r_rdata;
                alu_y  = r_amt;
            end
            ST_RETURN: begin
                alu_x = r_acc[up];
                alu_y = r_ret;
            end
            default: ;
        endcase
    end

    // walker datapath controls
    always_comb begin
        n_k       = r_k;
        n_a       = r_a;
        n_b       = r_b;
        n_d       = r_d;
        n_ret     = r_ret;
        n_tmp     = r_tmp;
        push_en   = 1'b0;
        acc_we    = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_k;
        mem_wdata = alu_r;
        mem_raddr = r_k;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    n_k = NODE_W'(1);
                    n_a = '0;
                    n_b = root_b;
                    n_d = '0;
                end
            end
            ST_VISIT: begin
                priority if (disjoint) begin
                    n_ret = '0;
                end else if (is_query && covered) begin
                    mem_raddr = r_k;
                end else if (!is_query && is_leaf) begin
                    mem_raddr = r_k;
                end else begin
                    push_en = 1'b1;
                    n_k     = {r_k[NODE_W-2:0], 1'b0};
                    n_b     = mid;
                    n_d     = r_d + LVL_W'(1);
                end
            end
            ST_QREAD: begin
                n_ret = r_rdata;
            end
            ST_LEAF_WR: begin
                mem_we = 1'b1;
            end
            ST_RETURN: begin
                if (r_d != '0) begin
                    if (!r_k[0]) begin
                        // left child done: park its value (query only), move to right sibling
                        n_k    = {r_k[NODE_W-1:1], 1'b1};
                        n_a    = pmid + LEAF_W'(1);
                        n_b    = pb;
                        acc_we = is_query;
                    end else begin
                        n_k   = {1'b0, r_k[NODE_W-1:1]};
                        n_a   = pa;
                        n_b   = pb;
                        n_d   = up;
                        n_ret = alu_r;
                    end
                end
            end
            ST_ADD_RDL: begin
                mem_raddr = {r_k[NODE_W-2:0], 1'b0};
            end
            ST_ADD_RDR: begin
                mem_raddr = {r_k[NODE_W-2:0], 1'b1};
                n_tmp     = r_rdata;
            end
            ST_ADD_WR: begin
                mem_we = 1'b1;
            end
            ST_PUSH: begin
                out_load = !r_out_valid || i_m_tready;
            end
            default: ;
        endcase
    end

    // node memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_mode      <= 1'b0;
            r_leaves    <= CNT_W'(MAX_LEAVES);
            r_out_valid <= 1'b0;
            r_d         <= '0;
        end else begin
            r_state <= n_state;
            r_d     <= n_d;
            if (r_state == ST_CLEAR) r_clr <= r_clr + NODE_W'(1);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_LEAVES: r_leaves <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and walk frames
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd <= i_s_tuser;
            r_lo  <= i_s_tdata[LEAF_W-1:0];
            r_hi  <= i_s_tdata[2*LEAF_W-1:LEAF_W];
            r_amt <= i_s_tdata[2*LEAF_W+VAL_W-1:2*LEAF_W];
        end
        r_k   <= n_k;
        r_a   <= n_a;
        r_b   <= n_b;
        r_ret <= n_ret;
        r_tmp <= n_tmp;
        if (push_en) begin
            r_stk_a[r_d] <= r_a;
            r_stk_b[r_d] <= r_b;
        end
        if (acc_we) r_acc[up] <= r_ret;
        if (out_load) r_out_data <= r_ret;
    end

    `STRQ_ASSERT_NOW(a_depth_bound, 1'b1, r_d <= LVL_W'(STK_DEPTH), "walk depth overrun")
    `STRQ_ASSERT_NEXT(a_walk_start, s_acc, (r_state == ST_VISIT) && (r_k == NODE_W'(1)) && (r_d == '0), "walk did not start at root")
    `STRQ_ASSERT_NOW(a_span_order, r_state == ST_VISIT, r_a <= r_b, "node span reversed")
    `STRQ_ASSERT_NOW(a_node_level, r_state == ST_VISIT, (r_k >> r_d) == NODE_W'(1), "node index off its level")

endmodule
